### hw/rtl/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types and constants shared by the filtered-derivative PID controller.
// ----------------------------------------------------------------------------
package pidfd_pkg;

   // operand and product widths of the shared multiplier
   localparam int OP_W   = 33;
   localparam int PROD_W = 2 * OP_W;

   // 1.0 in the alpha format
   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   // signed word limits
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   // register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_PROP_GAIN     = 3'd0;
   localparam csr_index_type CSR_INTEGRAL_RATE = 3'd1;
   localparam csr_index_type CSR_DERIV_GAIN    = 3'd2;
   localparam csr_index_type CSR_FEEDFWD_GAIN  = 3'd3;
   localparam csr_index_type CSR_INTEG_LIMIT   = 3'd4;
   localparam csr_index_type CSR_ALPHA_ERROR   = 3'd5;
   localparam csr_index_type CSR_ALPHA_DERIV   = 3'd6;
   localparam csr_index_type CSR_INV_STEP      = 3'd7;

   typedef struct packed {
      logic signed [31:0] setpoint;
      logic signed [31:0] measured;
      logic               limit_low;
      logic               limit_high;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] p_term;
      logic signed [31:0] i_term;
      logic signed [31:0] d_term;
      logic signed [31:0] ff_term;
      logic signed [31:0] error_filtered;
   } rsp_type;

   // sequencer states: each multiply state is followed by its accumulate state
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_MUL,
      ST_ERR_ACC,
      ST_RATE_MUL,
      ST_RATE_ACC,
      ST_DER_MUL,
      ST_DER_ACC,
      ST_INT_MUL,
      ST_INT_ACC,
      ST_P_MUL,
      ST_P_ACC,
      ST_D_MUL,
      ST_D_ACC,
      ST_F_MUL,
      ST_F_ACC,
      ST_DONE
   } state_type;

   // saturate a wide signed value to one signed word
   function automatic logic signed [31:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > PROD_W'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < PROD_W'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // coefficients above one count as one
   function automatic logic [16:0] clamp_alpha(input logic [16:0] a);
      logic [16:0] r;
      r = (a > ALPHA_ONE) ? ALPHA_ONE : a;
      return r;
   endfunction

endpackage

### hw/rtl/pidfd_if.sv
// ----------------------------------------------------------------------------
// pidfd_if
// Valid/ready channels for controller samples and controller results.
// ----------------------------------------------------------------------------

// sample channel
interface pidfd_req_if;
   logic              valid;
   logic              ready;
   pidfd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// result channel
interface pidfd_rsp_if;
   logic              valid;
   logic              ready;
   pidfd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/pidfd_mul.sv
// ----------------------------------------------------------------------------
// pidfd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidfd_mul (
   input  logic                                  clock,
   input  logic signed [pidfd_pkg::OP_W-1:0]     op_a,
   input  logic signed [pidfd_pkg::OP_W-1:0]     op_b,
   output logic signed [pidfd_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [pidfd_pkg::PROD_W-1:0] prod_in;

   // full precision product
   assign prod_in = pidfd_pkg::PROD_W'(op_a) * pidfd_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hw/rtl/pid_filtered_error_derivative_unit.sv
// ----------------------------------------------------------------------------
// pid_filtered_error_derivative_unit
// PID controller with filtered error, filtered derivative and a clamped,
// limit-aware integrator, all in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one sample beat: setpoint, measurement and the two
//   output-limit flags. rsp_bus returns one beat per sample: drive and its
//   P, I, D and feed-forward terms plus the filtered error.
//   Gains, limits and filter coefficients are written on the csr_ port
//   while no sample is in flight. One multiplier is shared by all seven
//   products and a sequencer runs them in turn, a multiply state then an
//   accumulate state each. The first sample after reset skips the error
//   filter, rate and derivative steps, and a zero inv_step skips the rate
//   and derivative steps. A new sample is accepted only once the sequencer
//   is back in ST_IDLE, after the result of the last one is registered.
//   Results sit in an output register: a stalled receiver does not stop
//   the next sample from being computed, but that sample waits in ST_DONE
//   until the held result is taken.
//   Reset (synchronous, active high) clears the filter and integrator
//   state, restores the default registers and arms the first-sample load.
// ----------------------------------------------------------------------------
module pid_filtered_error_derivative_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  pidfd_pkg::csr_index_type  csr_index,
   input  logic [31:0]               csr_wdata,
   pidfd_req_if.sink                 req_bus,
   pidfd_rsp_if.source               rsp_bus
);

   localparam int OW = pidfd_pkg::OP_W;
   localparam int PW = pidfd_pkg::PROD_W;

   // configuration registers
   logic signed [31:0] prop_gain_ff, integral_rate_ff, deriv_gain_ff, feedfwd_gain_ff;
   logic [30:0]        integ_limit_ff, inv_step_ff;
   logic [16:0]        alpha_error_ff, alpha_deriv_ff;

   // sequencer and working state
   pidfd_pkg::state_type state_ff, state_in;
   logic               first_ff, first_in;
   logic signed [31:0] err_ff, err_in, prev_ff, prev_in, deriv_ff, deriv_in;
   logic signed [31:0] integ_ff, integ_in, raw_ff, raw_in, sp_ff, sp_in, rate_ff, rate_in;
   logic signed [31:0] p_ff, p_in, d_ff, d_in, f_ff, f_in;
   logic signed [51:0] acc_ff, acc_in;
   logic               lim_lo_ff, lim_lo_in, lim_hi_ff, lim_hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pidfd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [OW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [49:0]   prod_q16;
   logic signed [37:0]   prod_q28;

   // scratch values of the accumulate cycles
   logic signed [32:0] raw_diff;
   logic signed [50:0] sum_q16;
   logic signed [38:0] integ_sum, integ_lim;
   logic               hold;
   logic               accept;

   pidfd_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // floored right shifts of the product
   assign prod_q16 = prod_ff[PW-1:16];
   assign prod_q28 = prod_ff[PW-1:28];

   assign accept        = req_bus.valid && (state_ff == pidfd_pkg::ST_IDLE);
   assign req_bus.ready = (state_ff == pidfd_pkg::ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidfd_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = first_ff ? pidfd_pkg::ST_INT_MUL : pidfd_pkg::ST_ERR_MUL;
            end
         end
         pidfd_pkg::ST_ERR_MUL:  state_in = pidfd_pkg::ST_ERR_ACC;
         pidfd_pkg::ST_ERR_ACC: begin
            state_in = (inv_step_ff != '0) ? pidfd_pkg::ST_RATE_MUL : pidfd_pkg::ST_INT_MUL;
         end
         pidfd_pkg::ST_RATE_MUL: state_in = pidfd_pkg::ST_RATE_ACC;
         pidfd_pkg::ST_RATE_ACC: state_in = pidfd_pkg::ST_DER_MUL;
         pidfd_pkg::ST_DER_MUL:  state_in = pidfd_pkg::ST_DER_ACC;
         pidfd_pkg::ST_DER_ACC:  state_in = pidfd_pkg::ST_INT_MUL;
         pidfd_pkg::ST_INT_MUL:  state_in = pidfd_pkg::ST_INT_ACC;
         pidfd_pkg::ST_INT_ACC:  state_in = pidfd_pkg::ST_P_MUL;
         pidfd_pkg::ST_P_MUL:    state_in = pidfd_pkg::ST_P_ACC;
         pidfd_pkg::ST_P_ACC:    state_in = pidfd_pkg::ST_D_MUL;
         pidfd_pkg::ST_D_MUL:    state_in = pidfd_pkg::ST_D_ACC;
         pidfd_pkg::ST_D_ACC:    state_in = pidfd_pkg::ST_F_MUL;
         pidfd_pkg::ST_F_MUL:    state_in = pidfd_pkg::ST_F_ACC;
         pidfd_pkg::ST_F_ACC:    state_in = pidfd_pkg::ST_DONE;
         pidfd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = pidfd_pkg::ST_IDLE;
            end
         end
         default: state_in = pidfd_pkg::ST_IDLE;
      endcase
   end

   // multiplier operand selection
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         pidfd_pkg::ST_ERR_MUL: begin
            op_a = OW'(raw_ff) - OW'(err_ff);
            op_b = signed'(OW'(pidfd_pkg::clamp_alpha(alpha_error_ff)));
         end
         pidfd_pkg::ST_RATE_MUL: begin
            op_a = OW'(err_ff) - OW'(prev_ff);
            op_b = signed'(OW'(inv_step_ff));
         end
         pidfd_pkg::ST_DER_MUL: begin
            op_a = OW'(rate_ff) - OW'(deriv_ff);
            op_b = signed'(OW'(pidfd_pkg::clamp_alpha(alpha_deriv_ff)));
         end
         pidfd_pkg::ST_INT_MUL: begin
            op_a = OW'(err_ff);
            op_b = OW'(integral_rate_ff);
         end
         pidfd_pkg::ST_P_MUL: begin
            op_a = OW'(err_ff);
            op_b = OW'(prop_gain_ff);
         end
         pidfd_pkg::ST_D_MUL: begin
            op_a = OW'(deriv_ff);
            op_b = OW'(deriv_gain_ff);
         end
         pidfd_pkg::ST_F_MUL: begin
            op_a = OW'(sp_ff);
            op_b = OW'(feedfwd_gain_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      first_in  = first_ff;
      err_in    = err_ff;
      prev_in   = prev_ff;
      deriv_in  = deriv_ff;
      integ_in  = integ_ff;
      raw_in    = raw_ff;
      sp_in     = sp_ff;
      rate_in   = rate_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      f_in      = f_ff;
      acc_in    = acc_ff;
      lim_lo_in = lim_lo_ff;
      lim_hi_in = lim_hi_ff;

      raw_diff  = OW'(req_bus.payload.setpoint) - OW'(req_bus.payload.measured);
      sum_q16   = 51'(prod_q16) + 51'(err_ff);
      integ_sum = 39'(prod_q28) + 39'(integ_ff);
      integ_lim = signed'(39'(integ_limit_ff));
      hold      = (lim_lo_ff && err_ff[31]) || (lim_hi_ff && !err_ff[31] && (err_ff != '0));

      unique case (state_ff)
         pidfd_pkg::ST_IDLE: begin
            // capture the sample; the first one loads the error filter directly
            if (accept) begin
               raw_in    = pidfd_pkg::sat_word(PW'(raw_diff));
               sp_in     = req_bus.payload.setpoint;
               lim_lo_in = req_bus.payload.limit_low;
               lim_hi_in = req_bus.payload.limit_high;
               prev_in   = err_ff;
               if (first_ff) begin
                  first_in = 1'b0;
                  err_in   = pidfd_pkg::sat_word(PW'(raw_diff));
                  deriv_in = '0;
               end
            end
         end
         pidfd_pkg::ST_ERR_ACC: begin
            err_in = pidfd_pkg::sat_word(PW'(sum_q16));
         end
         pidfd_pkg::ST_RATE_ACC: begin
            rate_in = pidfd_pkg::sat_word(PW'(prod_q16));
         end
         pidfd_pkg::ST_DER_ACC: begin
            sum_q16  = 51'(prod_q16) + 51'(deriv_ff);
            deriv_in = pidfd_pkg::sat_word(PW'(sum_q16));
         end
         pidfd_pkg::ST_INT_ACC: begin
            // zero rate clears, a matching limit flag holds, else clamp
            if (integral_rate_ff == '0) begin
               integ_in = '0;
            end else if (!hold) begin
               priority if (integ_sum > integ_lim) begin
                  integ_in = integ_lim[31:0];
               end else if (integ_sum < -integ_lim) begin
                  integ_in = 32'(-integ_lim);
               end else begin
                  integ_in = integ_sum[31:0];
               end
            end
         end
         pidfd_pkg::ST_P_ACC: begin
            p_in   = pidfd_pkg::sat_word(PW'(prod_q16));
            acc_in = 52'(prod_q16) + 52'(integ_ff);
         end
         pidfd_pkg::ST_D_ACC: begin
            d_in   = pidfd_pkg::sat_word(PW'(prod_q16));
            acc_in = acc_ff + 52'(prod_q16);
         end
         pidfd_pkg::ST_F_ACC: begin
            f_in   = pidfd_pkg::sat_word(PW'(prod_q16));
            acc_in = acc_ff + 52'(prod_q16);
         end
         default: begin
            first_in = first_ff;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == pidfd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.drive          = pidfd_pkg::sat_word(PW'(acc_ff));
         rsp_data_in.p_term         = p_ff;
         rsp_data_in.i_term         = integ_ff;
         rsp_data_in.d_term         = d_ff;
         rsp_data_in.ff_term        = f_ff;
         rsp_data_in.error_filtered = err_ff;
      end
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidfd_pkg::ST_IDLE;
         first_ff     <= 1'b1;
         err_ff       <= '0;
         deriv_ff     <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         err_ff       <= err_in;
         deriv_ff     <= deriv_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      raw_ff      <= raw_in;
      sp_ff       <= sp_in;
      rate_ff     <= rate_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      lim_lo_ff   <= lim_lo_in;
      lim_hi_ff   <= lim_hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_rate_ff <= '0;
         deriv_gain_ff    <= '0;
         feedfwd_gain_ff  <= '0;
         integ_limit_ff   <= '0;
         alpha_error_ff   <= pidfd_pkg::ALPHA_ONE;
         alpha_deriv_ff   <= pidfd_pkg::ALPHA_ONE;
         inv_step_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pidfd_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= signed'(csr_wdata);
            pidfd_pkg::CSR_INTEGRAL_RATE: integral_rate_ff <= signed'(csr_wdata);
            pidfd_pkg::CSR_DERIV_GAIN:    deriv_gain_ff    <= signed'(csr_wdata);
            pidfd_pkg::CSR_FEEDFWD_GAIN:  feedfwd_gain_ff  <= signed'(csr_wdata);
            pidfd_pkg::CSR_INTEG_LIMIT:   integ_limit_ff   <= csr_wdata[30:0];
            pidfd_pkg::CSR_ALPHA_ERROR:   alpha_error_ff   <= csr_wdata[16:0];
            pidfd_pkg::CSR_ALPHA_DERIV:   alpha_deriv_ff   <= csr_wdata[16:0];
            pidfd_pkg::CSR_INV_STEP:      inv_step_ff      <= csr_wdata[30:0];
            default:                      inv_step_ff      <= inv_step_ff;
         endcase
      end
   end

endmodule
